[hw/rtl/bfsg_pkg.sv]
`default_nettype none

package bfsg_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int MAX_KB          = 16384;
  localparam int MIN_KB          = 4;

  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int CFG_KB_W  = 15;
  localparam int CYC_W     = 23;
  localparam int AMP_W     = 15;
  localparam int SAMPLE_W  = 16;
  localparam int INDEX_W   = 23;
  localparam int KB_W      = CFG_KB_W + 2;
  localparam int TOTAL_W   = $clog2(MAX_KB) + 10;

  localparam int QSIZE     = 1 << (TABLE_ADDR_BITS - 2);
  localparam int K_W       = TABLE_ADDR_BITS - 2;
  localparam int QS_DEPTH  = QSIZE + 1;
  localparam int QS_AW     = $clog2(QS_DEPTH);
  localparam int Q30_FRAC  = 30;
  localparam int Q30_W     = Q30_FRAC + 1;
  localparam int PROD_W    = AMP_W + Q30_W;

  localparam int DIV_STEPS = CYC_W + PHASE_BITS;
  localparam int DVD_W     = CYC_W + PHASE_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [63:0] Q30_ONE     = 64'd1 << Q30_FRAC;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [CFG_KB_W-1:0] RST_BUFFER_KB = CFG_KB_W'(4);
  localparam logic [CFG_KB_W-1:0] RST_LIMIT_KB  = CFG_KB_W'(16384);
  localparam logic [CYC_W-1:0]    RST_CYCLES    = CYC_W'(1);
  localparam logic [AMP_W-1:0]    RST_AMPLITUDE = AMP_W'(32766);
  localparam logic [TOTAL_W-1:0]  RST_TOTAL     = TOTAL_W'(2048);

  typedef enum logic [2:0] {
    REG_BUFFER_KB = 3'd0,
    REG_LIMIT_KB  = 3'd1,
    REG_CYCLES    = 3'd2,
    REG_AMPLITUDE = 3'd3,
    REG_IQ_MODE   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         quad;
    logic [INDEX_W-1:0] index;
    logic               last;
  } meta_t;

  typedef logic [QS_DEPTH-1:0][Q30_W-1:0] qs_table_t;

  // Quarter-wave sine in Q30 from a six-term nested series.
  function automatic qs_table_t qs_build();
    qs_table_t   tbl;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] d;
    logic [63:0] s;
    for (int k = 0; k < QS_DEPTH; k++) begin
      x  = (HALF_PI_Q30 * 64'(k)) >> (TABLE_ADDR_BITS - 2);
      x2 = (x * x) >> Q30_FRAC;
      t  = Q30_ONE;
      for (int n = 0; n < 6; n++) begin
        p = (x2 * t) >> Q30_FRAC;
        unique case (n)
          0: d = p / 64'd156;
          1: d = p / 64'd110;
          2: d = p / 64'd72;
          3: d = p / 64'd42;
          4: d = p / 64'd20;
          default: d = p / 64'd6;
        endcase
        t = (d >= Q30_ONE) ? 64'd0 : (Q30_ONE - d);
      end
      s = (x * t) >> Q30_FRAC;
      if (s > Q30_ONE) begin
        s = Q30_ONE;
      end
      tbl[k] = s[Q30_W-1:0];
    end
    return tbl;
  endfunction

  localparam qs_table_t QS_TABLE = qs_build();

endpackage

`default_nettype wire

[hw/rtl/bfsg_rom.sv]
`default_nettype none

module bfsg_rom (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [bfsg_pkg::QS_AW-1:0]  addr_a,
  input  wire logic [bfsg_pkg::QS_AW-1:0]  addr_b,
  output logic      [bfsg_pkg::Q30_W-1:0]  data_a,
  output logic      [bfsg_pkg::Q30_W-1:0]  data_b
);
  import bfsg_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= QS_TABLE[addr_a];
      data_b <= QS_TABLE[addr_b];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bfsg_div.sv]
`default_nettype none

module bfsg_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [bfsg_pkg::CYC_W-1:0]       cycles,
  input  wire logic [bfsg_pkg::TOTAL_W-1:0]     divisor,
  output logic                                  done,
  output logic      [bfsg_pkg::PHASE_BITS-1:0]  quotient
);
  import bfsg_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DVD_W-1:0]      dvd_r;
  logic [TOTAL_W-1:0]    rem_r;
  logic [TOTAL_W-1:0]    rem_nxt;
  logic [TOTAL_W-1:0]    div_r;
  logic [PHASE_BITS-1:0] quo_r;
  logic [TOTAL_W:0]      trial;
  logic                  fits;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_comb begin
    if (fits) begin
      rem_nxt = TOTAL_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = TOTAL_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {cycles, {PHASE_BITS{1'b0}}};
      rem_r <= '0;
      quo_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[PHASE_BITS-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not start");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (cnt_r == '0) && !start |=> done_r && !busy_r)
    else $error("divider did not finish after its last step");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < div_r)
    else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

[hw/rtl/bfsg_out.sv]
`default_nettype none

module bfsg_out (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  input  wire logic [bfsg_pkg::QS_AW-1:0]      addr_a,
  input  wire logic [bfsg_pkg::QS_AW-1:0]      addr_b,
  input  wire bfsg_pkg::meta_t                 meta,
  input  wire logic [bfsg_pkg::AMP_W-1:0]      amplitude,
  input  wire logic                            iq_mode,
  output logic                                 can_take,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [bfsg_pkg::SAMPLE_W-1:0] out_sine_value,
  output logic signed [bfsg_pkg::SAMPLE_W-1:0] out_cosine_value,
  output logic      [bfsg_pkg::INDEX_W-1:0]    out_sample_index,
  output logic                                 out_last
);
  import bfsg_pkg::*;

  logic                s1_v_r;
  meta_t               s1_meta_r;
  logic                out_v_r;
  logic                out_load;
  logic [Q30_W-1:0]    rom_a;
  logic [Q30_W-1:0]    rom_b;
  logic [PROD_W-1:0]   prod_a;
  logic [PROD_W-1:0]   prod_b;
  logic [AMP_W-1:0]    mag_a;
  logic [AMP_W-1:0]    mag_b;
  logic [AMP_W-1:0]    sin_mag;
  logic [AMP_W-1:0]    cos_mag;
  logic                sin_neg;
  logic                cos_neg;
  logic [SAMPLE_W-1:0] sin_nxt;
  logic [SAMPLE_W-1:0] cos_nxt;

  bfsg_rom u_rom (
    .clk    (clk),
    .en     (push),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .data_a (rom_a),
    .data_b (rom_b)
  );

  assign out_load = !out_v_r || out_ready;
  assign can_take = !s1_v_r || out_load;

  assign prod_a = PROD_W'(amplitude) * PROD_W'(rom_a);
  assign prod_b = PROD_W'(amplitude) * PROD_W'(rom_b);
  assign mag_a  = prod_a[Q30_FRAC +: AMP_W];
  assign mag_b  = prod_b[Q30_FRAC +: AMP_W];

  always_comb begin
    sin_mag = s1_meta_r.quad[0] ? mag_b : mag_a;
    cos_mag = s1_meta_r.quad[0] ? mag_a : mag_b;
    sin_neg = s1_meta_r.quad[1];
    cos_neg = s1_meta_r.quad[1] ^ s1_meta_r.quad[0];
    sin_nxt = sin_neg ? (SAMPLE_W'(0) - SAMPLE_W'(sin_mag)) : SAMPLE_W'(sin_mag);
    cos_nxt = cos_neg ? (SAMPLE_W'(0) - SAMPLE_W'(cos_mag)) : SAMPLE_W'(cos_mag);
    if (!iq_mode) begin
      cos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (can_take) begin
        s1_v_r <= push;
      end
      if (out_load) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      s1_meta_r <= meta;
    end
    if (out_load && s1_v_r) begin
      out_sine_value   <= sin_nxt;
      out_cosine_value <= cos_nxt;
      out_sample_index <= s1_meta_r.index;
      out_last         <= s1_meta_r.last;
    end
  end

  assign out_valid = out_v_r;

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_take)
    else $error("request pushed into a full stage");

  a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !out_load |=> s1_v_r)
    else $error("request dropped from the table stage");

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (mag_a <= amplitude) && (mag_b <= amplitude))
    else $error("sample magnitude above amplitude");

endmodule

`default_nettype wire

[hw/rtl/buffer_fitted_sine_generator.sv]
// Looping sine buffer generator for a DAC, one sample per request.
// Input channel (in_valid/in_ready/in_restart): each accepted request yields
// exactly one sample on the output channel. A request with in_restart set
// recomputes the buffer length and phase step and starts at sample zero.
// Output channel (out_valid/out_ready): sine, cosine (zero unless I/Q mode),
// sample index and a last flag on the final sample of the buffer.
// Configuration is written over the APB port at byte addresses 4*i.
// An ordinary request passes through the table stage and the output register,
// and requests flow at one request per cycle while the receiver keeps up and no restart is pending;
// a restart request waits for the 55-step bit-serial divider that forms the phase step.
// The quarter-wave table is a two-port synchronous ROM read in the cycle a
// sample is issued; the amplitude multiply follows in the next stage.
// After reset the buffer is 2048 samples with a zero phase step until the
// first restart, and the configuration holds its documented defaults.
// When the receiver stalls, one finished sample waits in the output register
// and one more in the table stage; further requests are held off.
`default_nettype none

module buffer_fitted_sine_generator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_restart,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [bfsg_pkg::SAMPLE_W-1:0] out_sine_value,
  output logic signed [bfsg_pkg::SAMPLE_W-1:0] out_cosine_value,
  output logic      [bfsg_pkg::INDEX_W-1:0]    out_sample_index,
  output logic                                 out_last,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bfsg_pkg::CFG_AW-1:0]     paddr,
  input  wire logic [bfsg_pkg::CFG_DW-1:0]     pwdata,
  output logic      [bfsg_pkg::CFG_DW-1:0]     prdata,
  output logic                                 pready
);
  import bfsg_pkg::*;

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_DIV   = 3'b010,
    ST_ISSUE = 3'b100
  } state_t;

  state_t                state_r;
  state_t                state_nxt;

  logic [CFG_KB_W-1:0]   buffer_kb_r;
  logic [CFG_KB_W-1:0]   limit_kb_r;
  logic [CYC_W-1:0]      cycles_r;
  logic [AMP_W-1:0]      amplitude_r;
  logic                  iq_mode_r;

  logic [INDEX_W-1:0]    index_r;
  logic [TOTAL_W-1:0]    total_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] step_r;

  logic                  cfg_wr;
  reg_idx_t              cfg_idx;
  logic                  accept;
  logic                  div_start;
  logic                  div_done;
  logic [PHASE_BITS-1:0] div_quo;
  logic                  can_take;
  logic                  issue;

  logic [KB_W-1:0]       lim_kb;
  logic [KB_W-1:0]       req_kb;
  logic [KB_W-1:0]       fit_kb;
  logic [TOTAL_W-1:0]    total_calc;

  logic [TABLE_ADDR_BITS-1:0] tab_addr;
  logic [K_W-1:0]             k_off;
  logic [QS_AW-1:0]           addr_a;
  logic [QS_AW-1:0]           addr_b;
  logic [TOTAL_W-1:0]         index_inc;
  logic                       is_last;
  meta_t                      meta;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_kb_r <= RST_BUFFER_KB;
      limit_kb_r  <= RST_LIMIT_KB;
      cycles_r    <= RST_CYCLES;
      amplitude_r <= RST_AMPLITUDE;
      iq_mode_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BUFFER_KB: buffer_kb_r <= pwdata[CFG_KB_W-1:0];
        REG_LIMIT_KB:  limit_kb_r  <= pwdata[CFG_KB_W-1:0];
        REG_CYCLES:    cycles_r    <= pwdata[CYC_W-1:0];
        REG_AMPLITUDE: amplitude_r <= pwdata[AMP_W-1:0];
        REG_IQ_MODE:   iq_mode_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BUFFER_KB: prdata = CFG_DW'(buffer_kb_r);
      REG_LIMIT_KB:  prdata = CFG_DW'(limit_kb_r);
      REG_CYCLES:    prdata = CFG_DW'(cycles_r);
      REG_AMPLITUDE: prdata = CFG_DW'(amplitude_r);
      REG_IQ_MODE:   prdata = CFG_DW'(iq_mode_r);
      default:       prdata = '0;
    endcase
  end

  // Clamp the request between 4 KB and the limit, then round up to a multiple of 4 KB.
  always_comb begin
    lim_kb = KB_W'(limit_kb_r);
    if (lim_kb < KB_W'(MIN_KB)) begin
      lim_kb = KB_W'(MIN_KB);
    end
    if (lim_kb > KB_W'(MAX_KB)) begin
      lim_kb = KB_W'(MAX_KB);
    end
    req_kb = KB_W'(buffer_kb_r);
    if (req_kb < KB_W'(MIN_KB)) begin
      req_kb = KB_W'(MIN_KB);
    end
    if (req_kb > lim_kb) begin
      req_kb = lim_kb;
    end
    fit_kb = (req_kb + KB_W'(3)) & ~KB_W'(3);
    if (iq_mode_r) begin
      total_calc = TOTAL_W'({fit_kb, 8'b0});
    end else begin
      total_calc = TOTAL_W'({fit_kb, 9'b0});
    end
  end

  assign in_ready  = (state_r == ST_RUN) && can_take;
  assign accept    = in_valid && in_ready;
  assign div_start = accept && in_restart;
  assign issue     = (accept && !in_restart) || ((state_r == ST_ISSUE) && can_take);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN:   if (div_start) state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_ISSUE;
      ST_ISSUE: if (can_take) state_nxt = ST_RUN;
      default:  state_nxt = ST_RUN;
    endcase
  end

  assign tab_addr  = phase_r[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign k_off     = tab_addr[K_W-1:0];
  assign addr_a    = QS_AW'(k_off);
  assign addr_b    = QS_AW'(QSIZE) - QS_AW'(k_off);
  assign index_inc = TOTAL_W'(index_r) + TOTAL_W'(1);
  assign is_last   = index_inc >= total_r;

  always_comb begin
    meta.quad  = tab_addr[TABLE_ADDR_BITS-1 -: 2];
    meta.index = index_r;
    meta.last  = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      index_r <= '0;
      total_r <= RST_TOTAL;
      phase_r <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (div_done) begin
        step_r <= div_quo;
      end
      priority if (div_start) begin
        total_r <= total_calc;
        index_r <= '0;
        phase_r <= '0;
      end else if (issue) begin
        if (is_last) begin
          index_r <= '0;
          phase_r <= '0;
        end else begin
          index_r <= index_r + 1'b1;
          phase_r <= phase_r + step_r;
        end
      end
    end
  end

  bfsg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .cycles   (cycles_r),
    .divisor  (total_calc),
    .done     (div_done),
    .quotient (div_quo)
  );

  bfsg_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (issue),
    .addr_a           (addr_a),
    .addr_b           (addr_b),
    .meta             (meta),
    .amplitude        (amplitude_r),
    .iq_mode          (iq_mode_r),
    .can_take         (can_take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sine_value   (out_sine_value),
    .out_cosine_value (out_cosine_value),
    .out_sample_index (out_sample_index),
    .out_last         (out_last)
  );

  a_restart_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> state_r == ST_DIV)
    else $error("restart did not enter the division");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    TOTAL_W'(index_r) < total_r)
    else $error("sample index outside the buffer");

  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (phase_r == '0) && (index_r == '0))
    else $error("phase not at zero when the step is ready");

  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !issue && !in_ready)
    else $error("request taken during division");

endmodule

`default_nettype wire
